/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// payload must hold while the word waits
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

/* sv/isr_pkg.sv */
// constants and result kinds of the indexed sample trace ring
package isr_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = AW + 1;
    localparam int RW    = 32 + 32 + 4;

    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_NEXT     = 2'd1;
    localparam logic [1:0] KIND_UNDERRUN = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

/* sv/isr_ram.sv */
// generic single-write, single-read ram with registered read data
module isr_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/indexed_sample_trace_ring.sv */
// Ring of DEPTH sample records addressed by a 32-bit absolute sequence index. A record
// word is taken while idle and leaves the block idle, so samples can be recorded back to
// back. A readout word makes the block busy: S_NEXT and S_AGE form the next index and
// the start age on the one shared 32-bit adder and S_CHK classifies the request, then
// each emitted sample takes a registered ram read (S_RD) and a load of the output
// register (S_LD), then S_FIN gives the final next-index or underrun word. The output
// register lets the block take the next record word while the final readout word still
// waits to be taken.
module indexed_sample_trace_ring
    import isr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [31:0] i_timestamp_ms,
    input  logic [31:0] i_value_bits,
    input  logic [3:0]  i_source,
    input  logic        i_has_start,
    input  logic [31:0] i_start_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_out_timestamp_ms,
    output logic [31:0] o_out_value_bits,
    output logic [3:0]  o_out_source,
    output logic [31:0] o_next_index,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_AGE,
        S_CHK,
        S_RD,
        S_LD,
        S_FIN
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_wp;
    logic [31:0]    r_base;
    logic [31:0]    r_next;
    logic [31:0]    r_age;
    logic [31:0]    r_start;
    logic           r_has_start;
    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_slot;
    logic [1:0]     r_fin_kind;

    logic           r_out_valid;
    logic [1:0]     r_kind;
    logic [31:0]    r_ts;
    logic [31:0]    r_val;
    logic [3:0]     r_src;
    logic [31:0]    r_nidx;
    logic           r_last;

    logic           in_acc;
    logic           out_free;
    logic           out_load;
    logic           rec_we;
    logic [31:0]    unit_a;
    logic [31:0]    unit_b;
    logic           unit_cin;
    logic [31:0]    unit_sum;
    logic           wrapped;
    logic [CW-1:0]  retained;
    logic [CW-1:0]  age_lo;
    logic           too_far;
    logic [SW-1:0]  wp_ext;
    logic [SW-1:0]  age_s;
    logic [SW-1:0]  start_slot;
    logic [RW-1:0]  ram_wdata;
    logic [RW-1:0]  ram_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rec_we     = in_acc && (i_op == OP_RECORD);
    assign out_free   = !r_out_valid || i_out_ready;
    // a new word goes into the output register this cycle
    assign out_load   = out_free && (r_state inside {S_LD, S_FIN});

    // the one shared adder: wrap base step, next index, start age
    always_comb begin
        unit_a   = r_base;
        unit_b   = 32'(DEPTH);
        unit_cin = 1'b0;
        case (r_state)
            S_NEXT: begin
                unit_b = 32'(r_wp);
            end
            S_AGE: begin
                unit_a   = r_next;
                unit_b   = ~r_start;
                unit_cin = 1'b1;
            end
            default: begin
                unit_b = 32'(DEPTH);
            end
        endcase
        unit_sum = unit_a + unit_b + 32'(unit_cin);
    end

    assign wrapped  = (r_base != 32'd0);
    assign retained = wrapped ? CW'(DEPTH) : CW'(r_wp);
    assign age_lo   = r_age[CW-1:0];
    assign too_far  = (r_age[31:CW] != '0) || (age_lo > retained);

    // first slot of the run: the sample at the start index, read on toward the newest
    assign wp_ext     = SW'(r_wp);
    assign age_s      = SW'(age_lo);
    assign start_slot = (age_s > wp_ext) ? (wp_ext + SW'(DEPTH) - age_s) : (wp_ext - age_s);

    assign ram_wdata = {i_timestamp_ms, i_value_bits, i_source};

    isr_ram #(
        .W (RW),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OP_RECORD) begin
                            if (r_wp == AW'(DEPTH - 1)) begin
                                r_wp   <= '0;
                                r_base <= unit_sum;
                            end else begin
                                r_wp <= r_wp + AW'(1);
                            end
                        end else begin
                            r_has_start <= i_has_start;
                            r_start     <= i_start_index;
                            r_state     <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    r_next  <= unit_sum;
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    r_age   <= unit_sum;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_fin_kind <= KIND_NEXT;
                    if (!r_has_start || r_age == 32'd0) begin
                        r_state <= S_FIN;
                    end else if (too_far) begin
                        // overwritten start gives underrun, a start ahead gives next only
                        if (wrapped && !r_age[31]) begin
                            r_fin_kind <= KIND_UNDERRUN;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_cnt   <= age_lo;
                        r_slot  <= start_slot[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_SAMPLE;
                        r_ts        <= ram_rdata[RW-1:36];
                        r_val       <= ram_rdata[35:4];
                        r_src       <= ram_rdata[3:0];
                        r_nidx      <= r_next;
                        r_last      <= 1'b0;
                        r_cnt       <= r_cnt - CW'(1);
                        r_slot      <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);
                        r_state     <= (r_cnt == CW'(1)) ? S_FIN : S_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= r_fin_kind;
                        r_ts        <= '0;
                        r_val       <= '0;
                        r_src       <= '0;
                        r_nidx      <= r_next;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_out_timestamp_ms = r_ts;
    assign o_out_value_bits   = r_val;
    assign o_out_source       = r_src;
    assign o_next_index       = r_nidx;
    assign o_last             = r_last;

endmodule

/* sv/isr_checker.sv */
// port-level checks for the indexed sample trace ring, bound to the top level
`include "assert_macros.svh"

module isr_checker
    import isr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_kind,
    input  logic [31:0] o_out_timestamp_ms,
    input  logic [31:0] o_out_value_bits,
    input  logic [3:0]  o_out_source,
    input  logic [31:0] o_next_index,
    input  logic        o_last
);

    logic stall;
    logic mark_ok;
    logic info_word;
    logic data_zero;
    logic mid_run;

    assign stall     = o_out_valid && !i_out_ready;
    assign mark_ok   = (o_last == (o_kind != KIND_SAMPLE));
    assign info_word = o_out_valid && (o_kind != KIND_SAMPLE);
    assign data_zero = (o_out_timestamp_ms == 32'd0) && (o_out_value_bits == 32'd0)
                       && (o_out_source == 4'd0);
    assign mid_run   = o_out_valid && !o_last;

    `ASSERT_CLK(a_out_valid_holds, i_clk, i_rst_n, stall |=> o_out_valid, "word dropped")
    `ASSERT_HOLD(a_out_index_holds, i_clk, i_rst_n, stall, o_next_index, "index moved")
    `ASSERT_CLK(a_last_vs_kind, i_clk, i_rst_n, o_out_valid |-> mark_ok, "last vs kind")
    `ASSERT_CLK(a_empty_payload, i_clk, i_rst_n, info_word |-> data_zero, "stray sample data")
    `ASSERT_CLK(a_busy_in_run, i_clk, i_rst_n, mid_run |-> !o_in_ready, "input taken mid run")

endmodule

bind indexed_sample_trace_ring isr_checker u_isr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_kind             (o_kind),
    .o_out_timestamp_ms (o_out_timestamp_ms),
    .o_out_value_bits   (o_out_value_bits),
    .o_out_source       (o_out_source),
    .o_next_index       (o_next_index),
    .o_last             (o_last)
);
